### src/sba_pkg.sv
// Shared constants, codes and state encoding for the slab block allocator.
`default_nettype none

package sba_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_SLABS_DEF  = 8;
    localparam int MAX_BLOCKS_DEF = 256;
    localparam int ADDR_BITS_DEF  = 32;

    // Fixed field widths of the channels
    localparam int OP_W       = 2;
    localparam int REQ_ADDR_W = 32;
    localparam int SIZE_W     = 24;
    localparam int RES_ADDR_W = 32;
    localparam int STATUS_W   = 3;
    localparam int BSIZE_W    = 13;
    localparam int HSIZE_W    = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Register reset values
    localparam logic [BSIZE_W-1:0] BSIZE_RESET = 13'd64;
    localparam logic [HSIZE_W-1:0] HSIZE_RESET = 9'd32;

    // Free moves a slab forward when its free count beats the front slab's by over a quarter of the front's capacity
    localparam int SHUFFLE_SHIFT = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE  = 1'b0,
        CFG_HEADER_SIZE = 1'b1
    } cfg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_GROW   = 2'd2,
        OP_SHRINK = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_NONE    = 3'd1,
        ST_NO_SLAB = 3'd2,
        ST_FULL    = 3'd3,
        ST_DOUBLE  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SLOT_LOAD,
        S_SLOT_TEST,
        S_ALLOC_MUL,
        S_ALLOC_ADD,
        S_FREE_DIV,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_PUSH,
        S_FRONT,
        S_GROW_DIV,
        S_GROW_SLOT,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

### src/sba_if.sv
// Handshake channel interfaces: request, response and configuration write.
`default_nettype none

interface sba_req_if;
    logic                          valid;
    logic                          ready;
    logic [sba_pkg::OP_W-1:0]       op;
    logic [sba_pkg::REQ_ADDR_W-1:0] address;
    logic [sba_pkg::SIZE_W-1:0]     region_size;
    logic                          header_inside;

    modport source (output valid, op, address, region_size, header_inside, input ready);
    modport sink   (input valid, op, address, region_size, header_inside, output ready);
endinterface

interface sba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sba_pkg::RES_ADDR_W-1:0] result_address;
    logic [sba_pkg::STATUS_W-1:0]   status;

    modport source (output valid, result_address, status, input ready);
    modport sink   (input valid, result_address, status, output ready);
endinterface

interface sba_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sba_pkg::CFG_IDX_W-1:0]  index;
    logic [sba_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/slab_block_allocator_core.sv
// Slab block allocator: one operation at a time under a small sequencer.
// Alloc visits slabs in search order until one has a free block, pops it and forms the address
// by a multiply and an add; shrink visits slabs until one is fully free and removes it; free
// divides the offset in each slab tried, scans its free stack for the block, pushes it and may
// promote the slab; grow divides the region size and takes the first unused slot. The bit-serial
// divider is shared. Reset clears slab count, slot use and control and loads the config defaults.
`default_nettype none

module slab_block_allocator_core #(
    parameter int MAX_SLABS  = sba_pkg::MAX_SLABS_DEF,
    parameter int MAX_BLOCKS = sba_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = sba_pkg::ADDR_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sba_req_if.sink    req,
    sba_rsp_if.source  rsp,
    sba_cfg_if.sink    cfg
);

    localparam int SLOT_W    = $clog2(MAX_SLABS);
    localparam int CNT_W     = $clog2(MAX_SLABS + 1);
    localparam int POS_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CAP_W     = $clog2(MAX_BLOCKS + 1);
    localparam int MEM_DEPTH = MAX_SLABS << POS_W;
    localparam int DIV_W     = (ADDR_BITS > sba_pkg::SIZE_W) ? ADDR_BITS : sba_pkg::SIZE_W;
    localparam int PROD_W    = POS_W + sba_pkg::BSIZE_W;

    // Control registers
    sba_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [MAX_SLABS-1:0] used_reg;
    logic              out_valid_reg, out_valid_next;
    logic [sba_pkg::BSIZE_W-1:0] bsize_reg;
    logic [sba_pkg::HSIZE_W-1:0] hsize_reg;

    // Working registers
    sba_pkg::op_t      op_reg, op_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [sba_pkg::SIZE_W-1:0] size_reg, size_next;
    logic              inside_reg, inside_next;
    logic [CNT_W-1:0]  p_reg, p_next;
    logic [SLOT_W-1:0] s_reg, s_next;
    logic [SLOT_W-1:0] cand_reg, cand_next;
    logic [ADDR_BITS-1:0] cur_base_reg, cur_base_next;
    logic [ADDR_BITS-1:0] cur_start_reg, cur_start_next;
    logic [CAP_W-1:0]  cur_cap_reg, cur_cap_next;
    logic [CAP_W-1:0]  cur_cnt_reg, cur_cnt_next;
    logic [CAP_W-1:0]  cur_mark_reg, cur_mark_next;
    logic [POS_W-1:0]  idx_reg, idx_next;
    logic [CAP_W-1:0]  i_reg, i_next;
    logic              ident_reg, ident_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [sba_pkg::HSIZE_W-1:0] hdr_reg, hdr_next;
    logic [ADDR_BITS-1:0] res_reg, res_next;
    sba_pkg::status_t  status_reg, status_next;
    logic [sba_pkg::RES_ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [sba_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;

    // Per-slot tables and the search order
    logic [ADDR_BITS-1:0] base_reg  [MAX_SLABS];
    logic [ADDR_BITS-1:0] start_reg [MAX_SLABS];
    logic [CAP_W-1:0]     cap_reg   [MAX_SLABS];
    logic [CAP_W-1:0]     fcnt_reg  [MAX_SLABS];
    logic [CAP_W-1:0]     mark_reg  [MAX_SLABS];
    logic [SLOT_W-1:0]    order_reg [MAX_SLABS];

    // Free-stack memory; positions below a slab's mark are read as their own index, not from memory
    logic [POS_W-1:0] stack_mem [MEM_DEPTH];
    logic [POS_W-1:0] mem_q;
    logic             mem_we, mem_re;
    logic [SLOT_W+POS_W-1:0] mem_waddr, mem_raddr;
    logic [POS_W-1:0] mem_wdata;

    // Update strobes
    logic             slot_we, fcnt_we, mark_we, used_set, used_clr;
    logic             ord_mtf, ord_remove, ord_push, count_inc, count_dec;
    logic [CAP_W-1:0] fcnt_wdata, mark_wdata;

    // Divider hookup
    logic             div_start, div_done;
    logic [DIV_W-1:0] div_dividend, div_quot;
    logic [sba_pkg::BSIZE_W-1:0] div_rem;

    // Combinational scratch
    logic [SLOT_W-1:0]    sel_slot, front_slot;
    logic [ADDR_BITS-1:0] off;
    logic [CAP_W:0]       thr;
    logic [POS_W-1:0]     idx_val;
    logic [sba_pkg::HSIZE_W-1:0] hdr;
    logic [CAP_W-1:0]     cap_val;
    logic [CAP_W-1:0]     pos;

    sba_divider #(
        .DIV_W (DIV_W),
        .DSR_W (sba_pkg::BSIZE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (bsize_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign req.ready          = (state_reg == sba_pkg::S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.result_address = out_addr_reg;
    assign rsp.status         = out_status_reg;
    assign cfg.ready          = 1'b1;

    // Sequencer: next state, working registers and table strobes
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        size_next       = size_reg;
        inside_next     = inside_reg;
        p_next          = p_reg;
        s_next          = s_reg;
        cand_next       = cand_reg;
        cur_base_next   = cur_base_reg;
        cur_start_next  = cur_start_reg;
        cur_cap_next    = cur_cap_reg;
        cur_cnt_next    = cur_cnt_reg;
        cur_mark_next   = cur_mark_reg;
        idx_next        = idx_reg;
        i_next          = i_reg;
        ident_next      = ident_reg;
        prod_next       = prod_reg;
        hdr_next        = hdr_reg;
        res_next        = res_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;

        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = {s_reg, cur_cnt_reg[POS_W-1:0]};
        mem_raddr  = {s_reg, i_reg[POS_W-1:0]};
        mem_wdata  = idx_reg;
        slot_we    = 1'b0;
        fcnt_we    = 1'b0;
        mark_we    = 1'b0;
        fcnt_wdata = cur_cnt_reg;
        mark_wdata = cur_mark_reg;
        used_set   = 1'b0;
        used_clr   = 1'b0;
        ord_mtf    = 1'b0;
        ord_remove = 1'b0;
        ord_push   = 1'b0;
        count_inc  = 1'b0;
        count_dec  = 1'b0;
        div_start  = 1'b0;
        div_dividend = '0;

        sel_slot   = order_reg[p_reg[SLOT_W-1:0]];
        front_slot = order_reg[0];
        off        = addr_reg - cur_start_reg;
        thr        = {1'b0, fcnt_reg[front_slot]}
                   + {1'b0, (cap_reg[front_slot] >> sba_pkg::SHUFFLE_SHIFT)};
        idx_val    = ident_reg ? cur_cnt_reg[POS_W-1:0] : mem_q;
        hdr        = inside_reg ? hsize_reg : '0;
        cap_val    = (div_quot > DIV_W'(MAX_BLOCKS)) ? CAP_W'(MAX_BLOCKS)
                                                    : div_quot[CAP_W-1:0];
        pos        = CAP_W'(cur_cnt_reg - 1'b1);

        case (state_reg)
            sba_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = sba_pkg::op_t'(req.op);
                    addr_next   = ADDR_BITS'(req.address);
                    size_next   = req.region_size;
                    inside_next = req.header_inside;
                    res_next    = '0;
                    state_next  = sba_pkg::S_CHECK;
                end
            end

            sba_pkg::S_CHECK:
            begin
                p_next = '0;
                case (op_reg)
                    sba_pkg::OP_FREE:
                    begin
                        if (bsize_reg == '0)
                        begin
                            status_next = sba_pkg::ST_NO_SLAB;
                            state_next  = sba_pkg::S_RESP;
                        end
                        else
                        begin
                            state_next = sba_pkg::S_SLOT_LOAD;
                        end
                    end
                    sba_pkg::OP_GROW:
                    begin
                        hdr_next = hdr;
                        if (count_reg == CNT_W'(MAX_SLABS) || bsize_reg == '0
                            || size_reg <= sba_pkg::SIZE_W'(hdr))
                        begin
                            status_next = sba_pkg::ST_FULL;
                            state_next  = sba_pkg::S_RESP;
                        end
                        else
                        begin
                            div_start    = 1'b1;
                            div_dividend = DIV_W'(size_reg - sba_pkg::SIZE_W'(hdr));
                            state_next   = sba_pkg::S_GROW_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = sba_pkg::S_SLOT_LOAD;
                    end
                endcase
            end

            // Fetch the tables of the slab at the current search position
            sba_pkg::S_SLOT_LOAD:
            begin
                if (p_reg >= count_reg)
                begin
                    status_next = (op_reg == sba_pkg::OP_FREE) ? sba_pkg::ST_NO_SLAB
                                                               : sba_pkg::ST_NONE;
                    state_next  = sba_pkg::S_RESP;
                end
                else
                begin
                    s_next         = sel_slot;
                    cur_base_next  = base_reg[sel_slot];
                    cur_start_next = start_reg[sel_slot];
                    cur_cap_next   = cap_reg[sel_slot];
                    cur_cnt_next   = fcnt_reg[sel_slot];
                    cur_mark_next  = mark_reg[sel_slot];
                    state_next     = sba_pkg::S_SLOT_TEST;
                end
            end

            sba_pkg::S_SLOT_TEST:
            begin
                case (op_reg)
                    sba_pkg::OP_ALLOC:
                    begin
                        if (cur_cnt_reg == '0)
                        begin
                            p_next     = CNT_W'(p_reg + 1'b1);
                            state_next = sba_pkg::S_SLOT_LOAD;
                        end
                        else
                        begin
                            // Pop the top of the stack
                            fcnt_we      = 1'b1;
                            fcnt_wdata   = pos;
                            mem_re       = 1'b1;
                            mem_raddr    = {s_reg, pos[POS_W-1:0]};
                            ident_next   = pos < cur_mark_reg;
                            cur_cnt_next = pos;
                            state_next   = sba_pkg::S_ALLOC_MUL;
                        end
                    end
                    sba_pkg::OP_SHRINK:
                    begin
                        if (cur_cnt_reg == cur_cap_reg)
                        begin
                            res_next    = cur_base_reg;
                            ord_remove  = 1'b1;
                            used_clr    = 1'b1;
                            count_dec   = 1'b1;
                            status_next = sba_pkg::ST_OK;
                            state_next  = sba_pkg::S_RESP;
                        end
                        else
                        begin
                            p_next     = CNT_W'(p_reg + 1'b1);
                            state_next = sba_pkg::S_SLOT_LOAD;
                        end
                    end
                    default:
                    begin
                        div_start    = 1'b1;
                        div_dividend = DIV_W'(off);
                        state_next   = sba_pkg::S_FREE_DIV;
                    end
                endcase
            end

            sba_pkg::S_ALLOC_MUL:
            begin
                prod_next  = PROD_W'(idx_val) * PROD_W'(bsize_reg);
                state_next = sba_pkg::S_ALLOC_ADD;
            end

            sba_pkg::S_ALLOC_ADD:
            begin
                res_next    = cur_start_reg + ADDR_BITS'(prod_reg);
                ord_mtf     = 1'b1;
                status_next = sba_pkg::ST_OK;
                state_next  = sba_pkg::S_RESP;
            end

            // Block boundary and range check on the divided offset
            sba_pkg::S_FREE_DIV:
            begin
                if (div_done)
                begin
                    if (div_rem != '0 || div_quot >= DIV_W'(cur_cap_reg))
                    begin
                        p_next     = CNT_W'(p_reg + 1'b1);
                        state_next = sba_pkg::S_SLOT_LOAD;
                    end
                    else
                    begin
                        idx_next   = div_quot[POS_W-1:0];
                        i_next     = '0;
                        state_next = sba_pkg::S_SCAN_RD;
                    end
                end
            end

            // Walk the free stack looking for the same block
            sba_pkg::S_SCAN_RD:
            begin
                if (i_reg >= cur_cnt_reg)
                begin
                    state_next = sba_pkg::S_PUSH;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {s_reg, i_reg[POS_W-1:0]};
                    state_next = sba_pkg::S_SCAN_CMP;
                end
            end

            sba_pkg::S_SCAN_CMP:
            begin
                if (((i_reg < cur_mark_reg) ? i_reg[POS_W-1:0] : mem_q) == idx_reg)
                begin
                    status_next = sba_pkg::ST_DOUBLE;
                    state_next  = sba_pkg::S_RESP;
                end
                else
                begin
                    i_next     = CAP_W'(i_reg + 1'b1);
                    state_next = sba_pkg::S_SCAN_RD;
                end
            end

            sba_pkg::S_PUSH:
            begin
                if (cur_cnt_reg >= cur_cap_reg)
                begin
                    status_next = sba_pkg::ST_DOUBLE;
                    state_next  = sba_pkg::S_RESP;
                end
                else
                begin
                    mem_we       = 1'b1;
                    fcnt_we      = 1'b1;
                    fcnt_wdata   = CAP_W'(cur_cnt_reg + 1'b1);
                    mark_we      = 1'b1;
                    mark_wdata   = (cur_cnt_reg < cur_mark_reg) ? cur_cnt_reg : cur_mark_reg;
                    cur_cnt_next = CAP_W'(cur_cnt_reg + 1'b1);
                    status_next  = sba_pkg::ST_OK;
                    state_next   = (p_reg == '0) ? sba_pkg::S_RESP : sba_pkg::S_FRONT;
                end
            end

            // Promote the slab when it clearly beats the front slab
            sba_pkg::S_FRONT:
            begin
                if ({1'b0, cur_cnt_reg} > thr)
                begin
                    ord_mtf = 1'b1;
                end
                state_next = sba_pkg::S_RESP;
            end

            sba_pkg::S_GROW_DIV:
            begin
                if (div_done)
                begin
                    if (cap_val == '0)
                    begin
                        status_next = sba_pkg::ST_FULL;
                        state_next  = sba_pkg::S_RESP;
                    end
                    else
                    begin
                        cur_cap_next = cap_val;
                        cand_next    = '0;
                        state_next   = sba_pkg::S_GROW_SLOT;
                    end
                end
            end

            // Find an unused slot and install the region at the front
            sba_pkg::S_GROW_SLOT:
            begin
                if (!used_reg[cand_reg])
                begin
                    slot_we     = 1'b1;
                    used_set    = 1'b1;
                    ord_push    = 1'b1;
                    count_inc   = 1'b1;
                    status_next = sba_pkg::ST_OK;
                    state_next  = sba_pkg::S_RESP;
                end
                else
                begin
                    cand_next = SLOT_W'(cand_reg + 1'b1);
                end
            end

            sba_pkg::S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = (status_reg == sba_pkg::ST_OK)
                                    ? sba_pkg::RES_ADDR_W'(res_reg) : '0;
                    out_status_next = status_reg;
                    state_next      = sba_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sba_pkg::S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sba_pkg::S_IDLE;
            count_reg     <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            bsize_reg     <= sba_pkg::BSIZE_RESET;
            hsize_reg     <= sba_pkg::HSIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (count_inc)
            begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
            else if (count_dec)
            begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
            if (used_set)
            begin
                used_reg[cand_reg] <= 1'b1;
            end
            if (used_clr)
            begin
                used_reg[s_reg] <= 1'b0;
            end
            if (cfg.valid)
            begin
                case (sba_pkg::cfg_idx_t'(cfg.index))
                    sba_pkg::CFG_BLOCK_SIZE:  bsize_reg <= cfg.data[sba_pkg::BSIZE_W-1:0];
                    sba_pkg::CFG_HEADER_SIZE: hsize_reg <= cfg.data[sba_pkg::HSIZE_W-1:0];
                    default:                  bsize_reg <= bsize_reg;
                endcase
            end
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        size_reg       <= size_next;
        inside_reg     <= inside_next;
        p_reg          <= p_next;
        s_reg          <= s_next;
        cand_reg       <= cand_next;
        cur_base_reg   <= cur_base_next;
        cur_start_reg  <= cur_start_next;
        cur_cap_reg    <= cur_cap_next;
        cur_cnt_reg    <= cur_cnt_next;
        cur_mark_reg   <= cur_mark_next;
        idx_reg        <= idx_next;
        i_reg          <= i_next;
        ident_reg      <= ident_next;
        prod_reg       <= prod_next;
        hdr_reg        <= hdr_next;
        res_reg        <= res_next;
        status_reg     <= status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    // Slot tables and search order
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            base_reg[cand_reg]  <= addr_reg;
            start_reg[cand_reg] <= addr_reg + ADDR_BITS'(hdr_reg);
            cap_reg[cand_reg]   <= cur_cap_reg;
            fcnt_reg[cand_reg]  <= cur_cap_reg;
            mark_reg[cand_reg]  <= cur_cap_reg;
        end
        if (fcnt_we)
        begin
            fcnt_reg[s_reg] <= fcnt_wdata;
        end
        if (mark_we)
        begin
            mark_reg[s_reg] <= mark_wdata;
        end
        for (int i = 0; i < MAX_SLABS; i++)
        begin
            if (ord_mtf)
            begin
                if (i == 0)
                begin
                    order_reg[i] <= order_reg[p_reg[SLOT_W-1:0]];
                end
                else if (i <= int'(p_reg))
                begin
                    order_reg[i] <= order_reg[i-1];
                end
            end
            else if (ord_remove)
            begin
                if (i >= int'(p_reg) && i + 1 < MAX_SLABS)
                begin
                    order_reg[i] <= order_reg[i+1];
                end
            end
            else if (ord_push)
            begin
                if (i == 0)
                begin
                    order_reg[i] <= cand_reg;
                end
                else
                begin
                    order_reg[i] <= order_reg[i-1];
                end
            end
        end
    end

    // Free-stack memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= stack_mem[mem_raddr];
        end
    end

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SLABS))
        else $error("slab count beyond table size");

    a_used_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == int'(count_reg))
        else $error("occupied slots disagree with slab count");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != sba_pkg::S_IDLE))
        else $error("sequencer did not start on accepted transfer");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != sba_pkg::ST_OK) |-> (rsp.result_address == '0))
        else $error("failed result carries an address");

endmodule

`default_nettype wire

### src/sba_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none

module sba_divider #(
    parameter int DIV_W = 32,
    parameter int DSR_W = 13
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DSR_W-1:0] divisor,
    output logic                  done,
    output logic      [DIV_W-1:0] quotient,
    output logic      [DSR_W-1:0] remainder
);

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DSR_W-1:0]  rem_reg, rem_next;
    logic [DSR_W-1:0]  dsr_reg, dsr_next;
    logic [DSR_W:0]    shifted;
    logic [DSR_W:0]    diff;
    logic              ge;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        ge      = shifted >= {1'b0, dsr_reg};
    end

    // Step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DIV_W-2:0], ge};
            rem_next  = ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
            step_next = STEP_W'(step_reg + 1'b1);
            if (step_reg == STEP_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire
